>>> hdl/bcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  // Register indexes on the configuration port
  localparam logic [3:0] REG_BALANCE_GAIN_P = 4'd0;
  localparam logic [3:0] REG_BALANCE_GAIN_D = 4'd1;
  localparam logic [3:0] REG_SPEED_GAIN_P   = 4'd2;
  localparam logic [3:0] REG_SPEED_GAIN_I   = 4'd3;
  localparam logic [3:0] REG_UPRIGHT_ANGLE  = 4'd4;
  localparam logic [3:0] REG_WANTED_SPEED   = 4'd5;
  localparam logic [3:0] REG_LOOP_LIMIT     = 4'd6;
  localparam logic [3:0] REG_TILT_LIMIT     = 4'd7;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } in_t;

  typedef struct packed {
    logic signed [10:0] drive;
    logic               motors_stopped;
    logic signed [15:0] balance_part;
    logic signed [15:0] speed_part;
  } out_t;

  typedef struct packed {
    logic signed [31:0] balance_gain_p;
    logic signed [31:0] balance_gain_d;
    logic signed [31:0] speed_gain_p;
    logic signed [31:0] speed_gain_i;
    logic signed [15:0] upright_angle;
    logic signed [16:0] wanted_speed;
    logic        [14:0] loop_limit;
    logic        [14:0] tilt_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_SPD_P,
    MUL_SPD_I,
    MUL_BAL_P,
    MUL_BAL_D
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_SUB,
    ACC_ADD8
  } acc_op_e;

  typedef struct packed {
    logic     load_in;
    logic     filt_en;
    logic     intg_en;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     sp_en;
    logic     bp_en;
    logic     out_load;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/balance_cascade_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-wheel balance controller: speed PI loop on a low-passed speed error
// plus a balance PD loop on roll angle and gyro rate, summed into one drive.
// Input channel (in_valid_i/in_ready_o/in_i) takes one control tick request
// with roll angle, gyro rate and both wheel counts. Output channel
// (out_valid_o/out_ready_i/out_o) returns drive, stop flag and both parts.
// Configuration channel writes one register per request; it is always ready
// and should be written only while no tick is in flight.
// One shared 32x32 multiplier runs four products through a sequencer, so a
// new request is taken only after the previous one has left the sequencer.
// The output sits in a register, so the sequencer keeps working while a
// result waits; if the receiver stalls, the next result holds in the
// datapath until the output register frees up, and input stays blocked.
// Reset restores default gains and limits and clears the filter and the
// integral. Beyond the tilt limit drive reads zero and the integral clears.
module balance_cascade_controller_core #(
  parameter int DRIVE_MAX          = 1000,
  parameter int INTEGRAL_USE_LIMIT = 10000
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire bcc_pkg::in_t                     in_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output bcc_pkg::out_t                         out_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bcc_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import bcc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // Register writes never stall
  assign cfg_ready_o = 1'b1;

  bcc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer: accept, filter, integrate, four multiply steps with accumulate and clamp, output
  bcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath: filter and integral state, shared multiplier, clamps
  bcc_dpath #(
    .DRIVE_MAX          (DRIVE_MAX),
    .INTEGRAL_USE_LIMIT (INTEGRAL_USE_LIMIT)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  // An accepted request must take the sequencer out of idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready right after accepting a request");

  // Stopped motors always read zero drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.motors_stopped |-> out_o.drive == '0)
    else $error("drive nonzero while motors stopped");

  // Clamping keeps the sign of the summed loop parts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.motors_stopped
      && ($signed(out_o.speed_part) + $signed(out_o.balance_part) > 0)
      |-> $signed(out_o.drive) > 0)
    else $error("drive sign disagrees with loop sum");
`endif

endmodule

`default_nettype wire

>>> hdl/bcc_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bcc_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [bcc_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output bcc_pkg::cfg_t                         cfg_o
);
  import bcc_pkg::*;

  cfg_t cfg_q;

  assign cfg_o = cfg_q;

  // Writes to unknown indexes drop silently
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.balance_gain_p <= 32'sd3932160;
      cfg_q.balance_gain_d <= -32'sd11796;
      cfg_q.speed_gain_p   <= 32'sd11141120;
      cfg_q.speed_gain_i   <= 32'sd55706;
      cfg_q.upright_angle  <= '0;
      cfg_q.wanted_speed   <= '0;
      cfg_q.loop_limit     <= 15'd1000;
      cfg_q.tilt_limit     <= 15'd10240;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BALANCE_GAIN_P: cfg_q.balance_gain_p <= cfg_data_i;
        REG_BALANCE_GAIN_D: cfg_q.balance_gain_d <= cfg_data_i;
        REG_SPEED_GAIN_P:   cfg_q.speed_gain_p   <= cfg_data_i;
        REG_SPEED_GAIN_I:   cfg_q.speed_gain_i   <= cfg_data_i;
        REG_UPRIGHT_ANGLE:  cfg_q.upright_angle  <= cfg_data_i[15:0];
        REG_WANTED_SPEED:   cfg_q.wanted_speed   <= cfg_data_i[16:0];
        REG_LOOP_LIMIT:     cfg_q.loop_limit     <= cfg_data_i[14:0];
        REG_TILT_LIMIT:     cfg_q.tilt_limit     <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/bcc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bcc_ctrl (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output bcc_pkg::cmd_t cmd_o
);
  import bcc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,
    ST_INTG,
    ST_MSP,
    ST_MSI,
    ST_ASI,
    ST_SPC,
    ST_MBD,
    ST_ABD,
    ST_BPC,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_SPD_P;
    cmd_o.acc_op   = ACC_HOLD;
    case (state_q)
      ST_IDLE: cmd_o.load_in = in_valid_i;
      ST_FILT: begin
        cmd_o.filt_en = 1'b1;
        cmd_o.acc_op  = ACC_CLR;
      end
      ST_INTG: cmd_o.intg_en = 1'b1;
      ST_MSP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SPD_P;
      end
      ST_MSI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SPD_I;
        cmd_o.acc_op  = ACC_SUB;
      end
      ST_ASI: cmd_o.acc_op = ACC_SUB;
      ST_SPC: begin
        cmd_o.sp_en   = 1'b1;
        cmd_o.acc_op  = ACC_CLR;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BAL_P;
      end
      ST_MBD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BAL_D;
        cmd_o.acc_op  = ACC_SUB;
      end
      ST_ABD: cmd_o.acc_op = ACC_ADD8;
      ST_BPC: cmd_o.bp_en = 1'b1;
      ST_OUT: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_FILT;
        ST_FILT: state_q <= ST_INTG;
        ST_INTG: state_q <= ST_MSP;
        ST_MSP:  state_q <= ST_MSI;
        ST_MSI:  state_q <= ST_ASI;
        ST_ASI:  state_q <= ST_SPC;
        ST_SPC:  state_q <= ST_MBD;
        ST_MBD:  state_q <= ST_ABD;
        ST_ABD:  state_q <= ST_BPC;
        ST_BPC:  state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/bcc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module bcc_dpath #(
  parameter int DRIVE_MAX          = 1000,
  parameter int INTEGRAL_USE_LIMIT = 10000
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bcc_pkg::cfg_t cfg_i,
  input  wire bcc_pkg::cmd_t cmd_i,
  input  wire bcc_pkg::in_t  in_i,
  output bcc_pkg::out_t      out_o
);
  import bcc_pkg::*;

  localparam int DMAX = (DRIVE_MAX > 1023) ? 1023 : DRIVE_MAX;
  localparam logic signed [16:0] DMAX_POS = 17'(DMAX);
  localparam logic signed [16:0] DMAX_NEG = -DMAX_POS;
  localparam logic signed [40:0] ILIM_POS = 41'(INTEGRAL_USE_LIMIT * 256);
  localparam logic signed [40:0] ILIM_NEG = -ILIM_POS;

  in_t                in_q;
  out_t               out_q;
  logic signed [31:0] fe_q, fe_d;
  logic signed [39:0] int_q, int_sat;
  logic signed [31:0] used_q, used_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [65:0] acc_q, acc_d;
  logic signed [15:0] sp_q, bp_q, loop_c;

  logic signed [18:0] err_c;
  logic signed [40:0] filt_prod;
  logic signed [25:0] filt_new;
  logic signed [33:0] filt_sum;
  logic signed [40:0] int_sum, int_ext;
  logic signed [31:0] mul_a, mul_b;
  logic signed [16:0] ang_diff;
  logic signed [41:0] acc_hi, lim_ext;
  logic signed [15:0] lim16;
  logic signed [16:0] roll_ext, tilt_ext, part_sum, drive_sat;
  logic               stopped;

  // Speed error and low-pass: 205/256 of old plus 51/256 of new, in Q.8
  always_comb begin
    err_c = {{2{cfg_i.wanted_speed[16]}}, cfg_i.wanted_speed}
          - ({{3{in_q.left_speed[15]}}, in_q.left_speed}
           + {{3{in_q.right_speed[15]}}, in_q.right_speed});
    filt_prod = $signed({{9{fe_q[31]}}, fe_q}) * 41'sd205;
    filt_new  = $signed({{7{err_c[18]}}, err_c}) * 26'sd51;
    filt_sum  = $signed({filt_prod[40], filt_prod[40:8]})
              + $signed({{8{filt_new[25]}}, filt_new});
    if (filt_sum[33:31] != {3{filt_sum[33]}}) begin
      fe_d = filt_sum[33] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      fe_d = filt_sum[31:0];
    end
  end

  // Integral saturates in storage, clamps where used
  always_comb begin
    int_sum = $signed({int_q[39], int_q}) + $signed({{9{fe_q[31]}}, fe_q});
    if (int_sum[40:39] != {2{int_sum[40]}}) begin
      int_sat = int_sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    end else begin
      int_sat = int_sum[39:0];
    end
    int_ext = {int_sat[39], int_sat};
    if (int_ext > ILIM_POS) begin
      used_d = ILIM_POS[31:0];
    end else if (int_ext < ILIM_NEG) begin
      used_d = ILIM_NEG[31:0];
    end else begin
      used_d = int_sat[31:0];
    end
  end

  // Shared multiplier
  always_comb begin
    ang_diff = {in_q.roll_angle[15], in_q.roll_angle}
             - {cfg_i.upright_angle[15], cfg_i.upright_angle};
    case (cmd_i.mul_sel)
      MUL_SPD_P: begin
        mul_a = cfg_i.speed_gain_p;
        mul_b = fe_q;
      end
      MUL_SPD_I: begin
        mul_a = cfg_i.speed_gain_i;
        mul_b = used_q;
      end
      MUL_BAL_P: begin
        mul_a = cfg_i.balance_gain_p;
        mul_b = {{15{ang_diff[16]}}, ang_diff};
      end
      MUL_BAL_D: begin
        mul_a = cfg_i.balance_gain_d;
        mul_b = {{16{in_q.gyro_rate[15]}}, in_q.gyro_rate};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Accumulator; the derivative term enters shifted by 8
  always_comb begin
    case (cmd_i.acc_op)
      ACC_HOLD: acc_d = acc_q;
      ACC_CLR:  acc_d = '0;
      ACC_SUB:  acc_d = acc_q - $signed({{2{prod_q[63]}}, prod_q});
      ACC_ADD8: acc_d = acc_q + $signed({prod_q[57:0], 8'b0});
      default:  acc_d = acc_q;
    endcase
  end

  // Floor by 2^24 and clamp to the loop limit
  always_comb begin
    acc_hi  = acc_q[65:24];
    lim_ext = {27'b0, cfg_i.loop_limit};
    lim16   = {1'b0, cfg_i.loop_limit};
    if (acc_hi > lim_ext) begin
      loop_c = lim16;
    end else if (acc_hi < -lim_ext) begin
      loop_c = -lim16;
    end else begin
      loop_c = acc_hi[15:0];
    end
  end

  always_comb begin
    roll_ext = {in_q.roll_angle[15], in_q.roll_angle};
    tilt_ext = {2'b0, cfg_i.tilt_limit};
    stopped  = (roll_ext < -tilt_ext) || (roll_ext > tilt_ext);
    part_sum = {sp_q[15], sp_q} + {bp_q[15], bp_q};
    if (part_sum > DMAX_POS) begin
      drive_sat = DMAX_POS;
    end else if (part_sum < DMAX_NEG) begin
      drive_sat = DMAX_NEG;
    end else begin
      drive_sat = part_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q  <= '0;
      int_q <= '0;
    end else begin
      if (cmd_i.filt_en) begin
        fe_q <= fe_d;
      end
      if (cmd_i.intg_en) begin
        int_q <= int_sat;
      end else if (cmd_i.out_load && stopped) begin
        int_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_i;
    if (cmd_i.intg_en) used_q <= used_d;
    if (cmd_i.mul_en) prod_q <= prod_d;
    acc_q <= acc_d;
    if (cmd_i.sp_en) sp_q <= loop_c;
    if (cmd_i.bp_en) bp_q <= loop_c;
    if (cmd_i.out_load) begin
      out_q.drive          <= stopped ? '0 : drive_sat[10:0];
      out_q.motors_stopped <= stopped;
      out_q.balance_part   <= bp_q;
      out_q.speed_part     <= sp_q;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire
